### src/rhap_pkg.sv
// ----------------------------------------------------------------------------
// rhap_pkg
// Shared widths, constants, controller states and the command and status
// structs of the ring history autoscale plot block.
// ----------------------------------------------------------------------------
`default_nettype none

package rhap_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int PRICE_W   = 24;
    localparam int X_W       = 6;
    localparam int Y_W       = 26;
    localparam int H_W       = 8;
    localparam int LO_W      = PRICE_W + 2;
    localparam int T_W       = PRICE_W + 1;
    localparam int NUM_W     = 32;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [H_W-1:0] H_RESET = H_W'(60);

    localparam logic FUNC_STORE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_ADJUST,
        ST_PT_READ,
        ST_PT_SUB,
        ST_DIV_LOAD,
        ST_DIV,
        ST_EMIT,
        ST_OUT
    } rhap_state_t;

    typedef struct packed {
        logic store;
        logic scan_start;
        logic scan_step;
        logic scan_flush;
        logic adjust;
        logic pt_read;
        logic pt_sub;
        logic div_load;
        logic div_step;
        logic emit;
        logic advance;
    } rhap_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic div_last;
        logic pt_last;
    } rhap_sts_t;

endpackage

`default_nettype wire

### src/rhap_ifc.sv
// ----------------------------------------------------------------------------
// rhap_ifc
// Valid/ready channels of the block: input items and plot points.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhap_item_if import rhap_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [PRICE_W-1:0] price;

    modport source (output valid, output func, output price, input ready);
    modport sink   (input valid, input func, input price, output ready);
endinterface

interface rhap_point_if import rhap_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [X_W-1:0]        x_pos;
    logic signed [Y_W-1:0] y_pos;
    logic                  last_point;
    logic                  empty_res;

    modport source (output valid, output x_pos, output y_pos, output last_point,
                    output empty_res, input ready);
    modport sink   (input valid, input x_pos, input y_pos, input last_point,
                    input empty_res, output ready);
endinterface

`default_nettype wire

### src/rhap_div.sv
// ----------------------------------------------------------------------------
// rhap_div
// Unsigned restoring divider, two quotient bits per step, for the point
// scaling of a render.
// ----------------------------------------------------------------------------
`default_nettype none

module rhap_div
    import rhap_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic               step,
    input  wire logic [NUM_W-1:0]   dividend,
    input  wire logic [PRICE_W-1:0] divisor,
    output logic [NUM_W-1:0]        quotient,
    output logic                    last
);

    logic [NUM_W-1:0]   q_reg, q_next;
    logic [PRICE_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0]  cnt_reg;

    logic [PRICE_W:0]   r1s, r2s, dvs;
    logic [PRICE_W-1:0] r1;
    logic               ge1, ge2;
    logic [NUM_W-1:0]   q1;

    always_comb
    begin
        dvs  = {1'b0, divisor};
        r1s  = {rem_reg, q_reg[NUM_W-1]};
        ge1  = (r1s >= dvs);
        r1   = ge1 ? PRICE_W'(r1s - dvs) : r1s[PRICE_W-1:0];
        q1   = {q_reg[NUM_W-2:0], ge1};
        r2s  = {r1, q1[NUM_W-1]};
        ge2  = (r2s >= dvs);
        rem_next = ge2 ? PRICE_W'(r2s - dvs) : r2s[PRICE_W-1:0];
        q_next   = {q1[NUM_W-2:0], ge2};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= '0;
        else if (step)
            cnt_reg <= cnt_reg + DCNT_W'(1);
    end

    assign quotient = q_reg;
    assign last     = (cnt_reg == DCNT_W'(DIV_STEPS - 1));

endmodule

`default_nettype wire

### src/rhap_ctrl.sv
// ----------------------------------------------------------------------------
// rhap_ctrl
// Controller: sequences store, min/max scan, span adjust and the per-point
// scaling and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rhap_ctrl
    import rhap_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire logic      item_func,
    input  wire logic      point_ready,
    input  wire rhap_sts_t sts,
    output logic           item_ready,
    output logic           point_valid,
    output rhap_cmd_t      cmd
);

    rhap_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        item_ready  = 1'b0;
        point_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_func == FUNC_STORE)
                        cmd.store = 1'b1;
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                cmd.scan_flush = 1'b1;
                state_next     = ST_ADJUST;
            end
            ST_ADJUST:
            begin
                cmd.adjust = 1'b1;
                state_next = ST_PT_READ;
            end
            ST_PT_READ:
            begin
                cmd.pt_read = 1'b1;
                state_next  = sts.found ? ST_PT_SUB : ST_EMIT;
            end
            ST_PT_SUB:
            begin
                cmd.pt_sub = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                point_valid = 1'b1;
                if (point_ready)
                begin
                    if (sts.pt_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_PT_READ;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/rhap_dp.sv
// ----------------------------------------------------------------------------
// rhap_dp
// Datapath: sample ring with valid bits, write pointer, min/max scan,
// span adjust, point scaling with the divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhap_dp
    import rhap_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rhap_cmd_t          cmd,
    output rhap_sts_t               sts,
    input  wire logic               cfg_we,
    input  wire logic [H_W-1:0]     cfg_wdata,
    input  wire logic [PRICE_W-1:0] price,
    output logic [X_W-1:0]          x_pos,
    output logic signed [Y_W-1:0]   y_pos,
    output logic                    last_point,
    output logic                    empty_res
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [PRICE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [PRICE_W-1:0] rdata_reg;
    logic               rvld_reg;

    logic [H_W-1:0]     h_reg;
    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      cnt_reg;
    logic               pend_reg;
    logic               found_reg;
    logic [PRICE_W-1:0] mn_reg, hi_reg;
    logic signed [LO_W-1:0] lo_reg;
    logic [PRICE_W-1:0] span_reg;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      k_reg;
    logic [T_W-1:0]     t_reg;

    logic [X_W-1:0]        x_reg;
    logic signed [Y_W-1:0] y_reg;
    logic                  last_reg;
    logic                  empty_reg;

    logic               rd_en;
    logic [AW-1:0]      raddr;
    logic [PRICE_W-1:0] v;
    logic               proc;
    logic [PRICE_W-1:0] span_raw;
    logic [H_W-1:0]     minspan;
    logic [H_W-1:0]     gap;
    logic signed [LO_W-1:0] tsum;
    logic [NUM_W-1:0]   prod;
    logic [NUM_W-1:0]   quotient;
    logic               div_last;

    assign rd_en = cmd.scan_step | cmd.pt_read;
    assign raddr = cmd.scan_step ? cnt_reg : slot_reg;
    assign v     = rvld_reg ? rdata_reg : '0;
    assign proc  = (cmd.scan_step & pend_reg) | cmd.scan_flush;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[wp_reg] <= price;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
            wp_reg   <= '0;
            h_reg    <= H_RESET;
        end
        else
        begin
            if (cfg_we)
                h_reg <= cfg_wdata;
            if (cmd.store)
            begin
                vld_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
            end
            if (rd_en)
                rvld_reg <= vld_reg[raddr];
        end
    end

    // scan: one read issued per cycle, previous read folded into min/max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                cnt_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                cnt_reg  <= cnt_reg + AW'(1);
                pend_reg <= 1'b1;
            end
            if (proc && v != '0)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && v != '0)
        begin
            if (!found_reg)
            begin
                mn_reg <= v;
                hi_reg <= v;
            end
            else
            begin
                if (v < mn_reg)
                    mn_reg <= v;
                if (v > hi_reg)
                    hi_reg <= v;
            end
        end
    end

    // widen a narrow span to the plot height, centered on the data
    always_comb
    begin
        span_raw = found_reg ? PRICE_W'(hi_reg - mn_reg) : '0;
        minspan  = (h_reg == '0) ? H_W'(1) : h_reg;
        gap      = minspan - span_raw[H_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.adjust)
        begin
            if (span_raw < PRICE_W'(minspan))
            begin
                lo_reg   <= $signed(LO_W'(found_reg ? mn_reg : '0))
                            - $signed(LO_W'(gap >> 1));
                span_reg <= PRICE_W'(minspan);
            end
            else
            begin
                lo_reg   <= $signed(LO_W'(mn_reg));
                span_reg <= span_raw;
            end
        end
        if (cmd.pt_sub)
            t_reg <= tsum[T_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            k_reg    <= '0;
        end
        else if (cmd.adjust)
        begin
            slot_reg <= wp_reg;
            k_reg    <= '0;
        end
        else if (cmd.advance)
        begin
            slot_reg <= (slot_reg == LAST_IDX) ? '0 : slot_reg + AW'(1);
            k_reg    <= k_reg + AW'(1);
        end
    end

    assign tsum = $signed(LO_W'(span_reg)) + lo_reg - $signed(LO_W'(v));
    assign prod = NUM_W'(h_reg) * NUM_W'(t_reg);

    rhap_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (prod),
        .divisor  (span_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            x_reg     <= X_W'(k_reg);
            y_reg     <= found_reg ? $signed(quotient[Y_W-1:0]) : $signed(Y_W'(h_reg));
            last_reg  <= (k_reg == LAST_IDX);
            empty_reg <= !found_reg;
        end
    end

    assign sts.scan_last = (cnt_reg == LAST_IDX);
    assign sts.found     = found_reg;
    assign sts.div_last  = div_last;
    assign sts.pt_last   = (k_reg == LAST_IDX);

    assign x_pos      = x_reg;
    assign y_pos      = y_reg;
    assign last_point = last_reg;
    assign empty_res  = empty_reg;

endmodule

`default_nettype wire

### src/ring_history_autoscale_plot.sv
// ----------------------------------------------------------------------------
// ring_history_autoscale_plot
// Ring of the last DEPTH price samples with an autoscaled plot render.
// ----------------------------------------------------------------------------
// channel  dir  transaction fields                        per transaction
// item     in   func, price                               store or render
// point    out  x_pos, y_pos, last_point, empty_res       one plot point
// cfg      in   cfg_we, cfg_wdata                         plot_height write
//
// Items are taken only in idle. Render: scan and span adjust through the
// single memory read port, then per point read, subtract, divider load and
// divide (two-bit-per-step divider, 16 steps) and emit, or read and emit
// when no sample is positive, each plus any wait on point.ready. Reset
// clears the ring through per-slot valid bits at once; no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_history_autoscale_plot
    import rhap_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [H_W-1:0] cfg_wdata,
    rhap_item_if.sink           item,
    rhap_point_if.source        point
);

    rhap_cmd_t cmd;
    rhap_sts_t sts;

    rhap_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_func   (item.func),
        .point_ready (point.ready),
        .sts         (sts),
        .item_ready  (item.ready),
        .point_valid (point.valid),
        .cmd         (cmd)
    );

    rhap_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .price      (item.price),
        .x_pos      (point.x_pos),
        .y_pos      (point.y_pos),
        .last_point (point.last_point),
        .empty_res  (point.empty_res)
    );

endmodule

`default_nettype wire

### src/rhap_chk.sv
// ----------------------------------------------------------------------------
// rhap_chk
// Port-level checks of the ring history autoscale plot, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rhap_chk
    import rhap_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  item_valid,
    input wire logic                  item_ready,
    input wire logic                  item_func,
    input wire logic                  point_valid,
    input wire logic                  point_ready,
    input wire logic [X_W-1:0]        point_x_pos,
    input wire logic signed [Y_W-1:0] point_y_pos,
    input wire logic                  point_last,
    input wire logic                  point_empty
);

    // hold a stalled point
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_ready |=> point_valid && $stable(point_x_pos)
        && $stable(point_y_pos) && $stable(point_last) && $stable(point_empty))
        else $error("stalled point changed");

    a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> !item_ready)
        else $error("item taken while a point is pending");

    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_func == FUNC_RENDER |=> !item_ready)
        else $error("render did not start");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && point_last |=> !point_valid && item_ready)
        else $error("render did not end after last point");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && !point_last |=> !point_valid && !item_ready)
        else $error("render left early");

endmodule

bind ring_history_autoscale_plot rhap_chk u_rhap_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .item_func   (item.func),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .point_x_pos (point.x_pos),
    .point_y_pos (point.y_pos),
    .point_last  (point.last_point),
    .point_empty (point.empty_res)
);

`default_nettype wire
